FILE: rtl/fhp_pkg.sv
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types, constants and collision helpers for the lattice gas cell
// update.
// ----------------------------------------------------------------------------
package fhp_pkg;

    localparam int NUM_LANES  = 6;
    localparam int CHAN_W     = 6;
    localparam int LANE_IDX_W = 3;
    localparam int DENSITY_W  = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ROWS_W = 10;
    localparam int CFG_COLS_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_COLS = 2'd1;

    localparam int ROWS_RESET = 500;
    localparam int COLS_RESET = 1000;
    localparam int GRID_MIN   = 3;

    // Field widths of the item
    localparam int CENTER_ROW_W = 9;
    localparam int CENTER_COL_W = 10;

    // Channel patterns
    localparam logic [CHAN_W-1:0] PAT_CH02  = 6'h05;
    localparam logic [CHAN_W-1:0] PAT_CH13  = 6'h0A;
    localparam logic [CHAN_W-1:0] PAT_CH45  = 6'h30;
    localparam logic [CHAN_W-1:0] PAT_CH124 = 6'h16;
    localparam logic [CHAN_W-1:0] PAT_CH035 = 6'h29;
    // channels 2, 3, 4 carry inflow / are dropped at outflow
    localparam logic [CHAN_W-1:0] MASK_FLOW = 6'h1C;

    typedef struct packed {
        logic [NUM_LANES*CHAN_W-1:0] neighbor_cells;
        logic [NUM_LANES-1:0]        neighbor_obstacles;
        logic [NUM_LANES-1:0]        neighbor_coins;
        logic [CHAN_W-1:0]           neighbor_inflow;
        logic [CENTER_ROW_W-1:0]     center_row;
        logic [CENTER_COL_W-1:0]     center_col;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]    new_cell;
        logic [DENSITY_W-1:0] density;
    } t_out_item;

    typedef logic [NUM_LANES-1:0][CHAN_W-1:0] t_lane_states;

    // Row offset to the upstream cell, biased by +1 (0 means -1).
    function automatic logic [1:0] lane_row_ofs(input logic [LANE_IDX_W-1:0] lane);
        logic [1:0] ofs;
        case (lane)
            3'd0:    ofs = 2'd2;
            3'd1:    ofs = 2'd1;
            3'd2:    ofs = 2'd0;
            3'd3:    ofs = 2'd1;
            3'd4:    ofs = 2'd2;
            3'd5:    ofs = 2'd0;
            default: ofs = 2'd1;
        endcase
        return ofs;
    endfunction

    // Column offset to the upstream cell, biased by +1.
    function automatic logic [1:0] lane_col_ofs(input logic [LANE_IDX_W-1:0] lane);
        logic [1:0] ofs;
        case (lane)
            3'd0:    ofs = 2'd2;
            3'd1:    ofs = 2'd2;
            3'd2:    ofs = 2'd0;
            3'd3:    ofs = 2'd0;
            3'd4:    ofs = 2'd0;
            3'd5:    ofs = 2'd2;
            default: ofs = 2'd1;
        endcase
        return ofs;
    endfunction

    function automatic logic [CHAN_W-1:0] collide(
        input logic [CHAN_W-1:0] s,
        input logic              coin,
        input logic              obstacle
    );
        logic [CHAN_W-1:0] res;
        res = s;
        if (!obstacle) begin
            case (s)
                PAT_CH02:  res = coin ? PAT_CH13 : PAT_CH45;
                PAT_CH13:  res = coin ? PAT_CH02 : PAT_CH45;
                PAT_CH45:  res = coin ? PAT_CH13 : PAT_CH02;
                PAT_CH124: res = PAT_CH035;
                PAT_CH035: res = PAT_CH124;
                default:   res = s;
            endcase
        end
        return res;
    endfunction

endpackage

FILE: rtl/fhp_lane.sv
// ----------------------------------------------------------------------------
// fhp_lane
// One upstream cell: collision, column inflow/outflow, top/bottom bounce.
// ----------------------------------------------------------------------------
module fhp_lane
    import fhp_pkg::*;
#(
    parameter int ROW_W = 10,
    parameter int COL_W = 11
) (
    input  logic [LANE_IDX_W-1:0]   i_lane,
    input  logic [CHAN_W-1:0]       i_cell,
    input  logic                    i_obstacle,
    input  logic                    i_coin,
    input  logic [CHAN_W-1:0]       i_inflow,
    input  logic [CENTER_ROW_W-1:0] i_row,
    input  logic [CENTER_COL_W-1:0] i_col,
    input  logic [ROW_W-1:0]        i_rows,
    input  logic [COL_W-1:0]        i_cols,
    output logic [CHAN_W-1:0]       o_state
);

    // Upstream position biased by +1, so -1 becomes 0.
    logic [ROW_W-1:0]  w_rp;
    logic [COL_W-1:0]  w_cp;
    logic              w_in_grid;
    logic              w_band;
    logic [CHAN_W-1:0] w_s;

    assign w_rp = ROW_W'(i_row) + ROW_W'(lane_row_ofs(i_lane));
    assign w_cp = COL_W'(i_col) + COL_W'(lane_col_ofs(i_lane));

    assign w_in_grid = (w_rp != '0) && (w_rp <= i_rows)
                    && (w_cp != '0) && (w_cp <= i_cols);

    // rows 1 .. rows-3 in unbiased terms
    assign w_band = (w_rp >= ROW_W'(2)) && (w_rp <= (i_rows - ROW_W'(2)));

    always_comb begin
        w_s = collide(i_cell, i_coin, i_obstacle);
        if (w_band) begin
            if (w_cp == COL_W'(1)) begin
                w_s = i_inflow & MASK_FLOW;
            end else if (w_cp == i_cols) begin
                w_s = w_s & ~MASK_FLOW;
            end
        end
        // top row
        if (w_rp == ROW_W'(1)) begin
            if (w_s[0]) begin
                w_s[0] = 1'b0;
                w_s[2] = 1'b1;
            end
            if (w_s[4]) begin
                w_s[4] = 1'b0;
                w_s[5] = 1'b1;
            end
        end
        // bottom row
        if (w_rp == i_rows) begin
            if (w_s[5]) begin
                w_s[5] = 1'b0;
                w_s[4] = 1'b1;
            end
            if (w_s[2]) begin
                w_s[2] = 1'b0;
                w_s[0] = 1'b1;
            end
        end
        o_state = w_in_grid ? w_s : '0;
    end

endmodule

FILE: rtl/fhp_merge.sv
// ----------------------------------------------------------------------------
// fhp_merge
// Picks channel k from lane k, counts occupancy, holds the output register.
// ----------------------------------------------------------------------------
module fhp_merge
    import fhp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_advance,
    input  logic         i_load,
    input  logic         i_center_ok,
    input  t_lane_states i_lane_state,
    output logic         o_valid,
    output t_out_item    o_item
);

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        n_item = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            n_item.new_cell[k] = i_lane_state[k][k] & i_center_ok;
        end
        for (int k = 0; k < NUM_LANES; k++) begin
            n_item.density = n_item.density + DENSITY_W'(n_item.new_cell[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/fhp_lattice_gas_cell_update.sv
// One cell of the next generation of a six-channel (FHP) lattice gas per item.
// Each item carries the six upstream cells of the target cell; six lanes run
// collision, left-column inflow / right-column outflow and top/bottom bounce
// on their upstream cell in parallel, and a merge stage takes channel k from
// lane k and counts the occupied channels. Throughput is one item per clock
// while the result side does not stall; each item passes the input register,
// then the registered merge output. Upstream cells outside the grid contribute
// nothing, and a target cell outside the grid gives an empty result. grid_rows /
// grid_cols are clamped to 3..MAX_ROWS / 3..MAX_COLS when written; write them
// only while the block is empty. The config port is always ready.
// ----------------------------------------------------------------------------
// fhp_lattice_gas_cell_update
// Top level: handshakes, grid size registers, lanes and merge stage.
// ----------------------------------------------------------------------------
module fhp_lattice_gas_cell_update
    import fhp_pkg::*;
#(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Size registers must hold both the register range and the clamp bound.
    localparam int RowBoundW = $clog2(MAX_ROWS + 1);
    localparam int ColBoundW = $clog2(MAX_COLS + 1);
    localparam int RowW      = (RowBoundW > CFG_ROWS_W) ? RowBoundW : CFG_ROWS_W;
    localparam int ColW      = (ColBoundW > CFG_COLS_W) ? ColBoundW : CFG_COLS_W;
    localparam int RowsInit  = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
    localparam int ColsInit  = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

    // ------------------------------------------------------------------
    // Grid size registers, stored already clamped
    // ------------------------------------------------------------------
    logic [RowW-1:0] r_rows;
    logic [ColW-1:0] r_cols;
    logic [RowW-1:0] w_wr_rows;
    logic [ColW-1:0] w_wr_cols;
    logic            w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_comb begin
        w_wr_rows = RowW'(i_cfg_data[CFG_ROWS_W-1:0]);
        if (w_wr_rows < RowW'(GRID_MIN)) begin
            w_wr_rows = RowW'(GRID_MIN);
        end else if (w_wr_rows > RowW'(MAX_ROWS)) begin
            w_wr_rows = RowW'(MAX_ROWS);
        end
        w_wr_cols = ColW'(i_cfg_data[CFG_COLS_W-1:0]);
        if (w_wr_cols < ColW'(GRID_MIN)) begin
            w_wr_cols = ColW'(GRID_MIN);
        end else if (w_wr_cols > ColW'(MAX_COLS)) begin
            w_wr_cols = ColW'(MAX_COLS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RowW'(RowsInit);
            r_cols <= ColW'(ColsInit);
        end else if (w_cfg_wr) begin
            if (i_cfg_index == CFG_IDX_GRID_ROWS) begin
                r_rows <= w_wr_rows;
            end else if (i_cfg_index == CFG_IDX_GRID_COLS) begin
                r_cols <= w_wr_cols;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register; the merge output register decouples the result side
    // ------------------------------------------------------------------
    logic     r_s1_valid;
    logic     n_s1_valid;
    t_in_item r_s1;
    logic     w_advance;
    logic     w_accept;

    // merge stage can take a new item when empty or being drained
    assign w_advance = !o_valid || !i_stall;
    assign o_stall   = r_s1_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= i_data;
        end
    end

    // ------------------------------------------------------------------
    // Lanes
    // ------------------------------------------------------------------
    t_lane_states w_lane_state;
    logic         w_center_ok;

    assign w_center_ok = (RowW'(r_s1.center_row) < r_rows)
                      && (ColW'(r_s1.center_col) < r_cols);

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        fhp_lane #(
            .ROW_W (RowW),
            .COL_W (ColW)
        ) u_lane (
            .i_lane     (LANE_IDX_W'(k)),
            .i_cell     (r_s1.neighbor_cells[k*CHAN_W +: CHAN_W]),
            .i_obstacle (r_s1.neighbor_obstacles[k]),
            .i_coin     (r_s1.neighbor_coins[k]),
            .i_inflow   (r_s1.neighbor_inflow),
            .i_row      (r_s1.center_row),
            .i_col      (r_s1.center_col),
            .i_rows     (r_rows),
            .i_cols     (r_cols),
            .o_state    (w_lane_state[k])
        );
    end

    // ------------------------------------------------------------------
    // Merge and output register
    // ------------------------------------------------------------------
    fhp_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_load       (r_s1_valid),
        .i_center_ok  (w_center_ok),
        .i_lane_state (w_lane_state),
        .o_valid      (o_valid),
        .o_item       (o_data)
    );

`ifndef SYNTHESIS
    // density always matches the bits delivered
    a_density: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.density == DENSITY_W'($countones(o_data.new_cell))))
        else $error("density does not match new_cell");

    // a held input item is not dropped while the merge stage is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> r_s1_valid)
        else $error("input register lost an item");

    // upstream stall only when the input register is occupied
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && o_valid))
        else $error("stall without a pending item");

    // grid sizes stay within the clamp range
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rows >= RowW'(GRID_MIN)) && (r_rows <= RowW'(MAX_ROWS))
        && (r_cols >= ColW'(GRID_MIN)) && (r_cols <= ColW'(MAX_COLS)))
        else $error("grid size out of range");
`endif

endmodule
